FILE: design/c8core_pkg.sv
// Shared types, constants and helper functions of the CHIP-8 instruction core.
// Used by every module of the design but c8core_ram; depends on nothing.
`default_nettype none
package c8core_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int MEM_AW        = $clog2(MEM_BYTES);
    localparam int STACK_DEPTH   = 16;
    localparam int SP_W          = $clog2(STACK_DEPTH + 1);
    localparam int STK_IW        = $clog2(STACK_DEPTH);
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
    localparam int COL_W         = $clog2(SCREEN_WIDTH);

    localparam logic [MEM_AW-1:0] PC_RESET = 12'h200;

    localparam logic [1:0] ACT_EXEC   = 2'd0;
    localparam logic [1:0] ACT_MEM_WR = 2'd1;
    localparam logic [1:0] ACT_MEM_RD = 2'd2;
    localparam logic [1:0] ACT_ROW_RD = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [MEM_AW-1:0] mem_address;
        logic [7:0]        mem_data;
        logic [ROW_W-1:0]  row_index;
        logic [15:0]       key_state;
        logic [7:0]        random_value;
    } t_in;

    typedef struct packed {
        logic [7:0]              read_byte;
        logic [SCREEN_WIDTH-1:0] row_pixels;
        logic [MEM_AW-1:0]       program_counter;
        logic                    screen_changed;
        logic                    sound_active;
        logic                    waiting_for_key;
        logic                    stack_error;
    } t_out;

    typedef enum logic [1:0] {
        K_EXEC,
        K_MEM_WR,
        K_MEM_RD,
        K_ROW_RD
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_in   item;
    } t_cmd;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    // hundreds, tens and units of a byte by reciprocal multiplication
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [13:0] h_prod;
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] t_prod;
        logic [3:0]  t;
        logic [3:0]  u;
        h_prod = 14'(v) * 14'd41;
        h      = h_prod[13:12];
        r      = 7'(v - 8'(h) * 8'd100);
        t_prod = 15'(r) * 15'd205;
        t      = t_prod[14:11];
        u      = 4'(r - 7'(t) * 7'd10);
        case (sel)
            2'd0:    bcd_digit = 8'(h);
            2'd1:    bcd_digit = 8'(t);
            default: bcd_digit = 8'(u);
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: design/chip8_instruction_core_unit.sv
// Top level of the CHIP-8 instruction core: front end, command queue, back end
// and the 4 KiB memory. Depends on c8core_pkg, c8core_front, c8core_back, c8core_ram.
//
//  channel | valid   | stall   | word
//  --------+---------+---------+--------------------
//  input   | i_valid | o_stall | i_data (t_in)
//  output  | o_valid | i_stall | o_data (t_out)
//
//  After reset the memory is swept to zero, one byte a cycle, with o_stall high.
//  Instruction fetch, each sprite row and each FX33, FX55 and FX65 byte take their own access
//  on the single memory port.
//  Two words queue ahead of the back end; a stalled result holds the back end in its last state.
`default_nettype none
module chip8_instruction_core_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire c8core_pkg::t_in  i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output c8core_pkg::t_out      o_data,
    input  wire logic             i_stall
);
    c8core_pkg::t_back_ctl                ctl;
    logic                                 cmd_valid;
    c8core_pkg::t_cmd                     cmd;
    logic                                 ram_we;
    logic [c8core_pkg::MEM_AW-1:0]        ram_addr;
    logic [7:0]                           ram_wdata;
    logic [7:0]                           ram_rdata;

    c8core_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .i_ctl       (ctl),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    c8core_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_ctl       (ctl),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

    c8core_ram #(
        .WIDTH (8),
        .DEPTH (c8core_pkg::MEM_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );
endmodule
`default_nettype wire

FILE: design/c8core_ram.sv
// Generic single-port RAM with registered read data.
// Stands alone; no package needed.
`default_nettype none
module c8core_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: design/c8core_front.sv
// Front end: accepts input words, classifies the action and queues commands.
// Depends on c8core_pkg.
`default_nettype none
module c8core_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire c8core_pkg::t_in       i_data,
    output logic                       o_stall,
    input  wire c8core_pkg::t_back_ctl i_ctl,
    output logic                       o_cmd_valid,
    output c8core_pkg::t_cmd           o_cmd
);
    c8core_pkg::t_cmd r_q [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             push;
    logic             pop;
    c8core_pkg::t_cmd n_cmd;

    always_comb begin
        n_cmd.item = i_data;
        case (i_data.action)
            c8core_pkg::ACT_EXEC:   n_cmd.kind = c8core_pkg::K_EXEC;
            c8core_pkg::ACT_MEM_WR: n_cmd.kind = c8core_pkg::K_MEM_WR;
            c8core_pkg::ACT_MEM_RD: n_cmd.kind = c8core_pkg::K_MEM_RD;
            default:                n_cmd.kind = c8core_pkg::K_ROW_RD;
        endcase
    end

    assign o_stall     = (r_cnt == 2'd2) || i_ctl.clearing;
    assign push        = i_valid && !o_stall;
    assign pop         = i_ctl.pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

FILE: design/c8core_back.sv
// Back end: clears memory after reset, then carries out queued commands
// and holds the machine state and the output register. Depends on c8core_pkg.
`default_nettype none
module c8core_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cmd_valid,
    input  wire c8core_pkg::t_cmd        i_cmd,
    output c8core_pkg::t_back_ctl        o_ctl,
    output logic                         o_ram_we,
    output logic [c8core_pkg::MEM_AW-1:0] o_ram_addr,
    output logic [7:0]                   o_ram_wdata,
    input  wire logic [7:0]              i_ram_rdata,
    output logic                         o_valid,
    output c8core_pkg::t_out             o_data,
    input  wire logic                    i_stall
);
    localparam int AW = c8core_pkg::MEM_AW;
    localparam int SW = c8core_pkg::SCREEN_WIDTH;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MEM_RD, S_FETCH_LO, S_DECODE, S_EXEC,
        S_SPR_RD, S_SPR_WR, S_BCD, S_STORE, S_LOAD_RD, S_LOAD_WR, S_TICK, S_DONE
    } t_state;

    t_state                           r_state;
    logic [AW-1:0]                    r_clr;
    c8core_pkg::t_in                  r_item;
    logic [15:0]                      r_op;
    logic [7:0]                       r_v [16];
    logic [AW-1:0]                    r_stack [c8core_pkg::STACK_DEPTH];
    logic [c8core_pkg::SP_W-1:0]      r_sp;
    logic [AW-1:0]                    r_pc;
    logic [15:0]                      r_i;
    logic [7:0]                       r_delay;
    logic [7:0]                       r_sound;
    logic                             r_draw;
    logic [SW-1:0]                    r_frame [c8core_pkg::SCREEN_HEIGHT];
    logic [3:0]                       r_cnt;
    logic [7:0]                       r_sx;
    logic [7:0]                       r_sy;
    logic [7:0]                       r_rb;
    logic [SW-1:0]                    r_rp;
    logic                             r_wait;
    logic                             r_serr;
    logic                             r_ovalid;
    c8core_pkg::t_out                 r_odata;

    logic [3:0]        x;
    logic [3:0]        y;
    logic [3:0]        n;
    logic [7:0]        nn;
    logic [AW-1:0]     nnn;
    logic [7:0]        vx;
    logic [7:0]        vy;
    logic [AW-1:0]     pc2;
    logic [AW-1:0]     pc4;
    logic [AW-1:0]     ia;
    logic              key_hit;
    logic              key_any;
    logic [3:0]        key_top;
    logic [8:0]        sum9;
    logic [16:0]       sum17;
    logic [2*SW-1:0]   spr_wide;
    logic [SW-1:0]     spr_mask;
    logic [c8core_pkg::ROW_W-1:0] spr_row;
    logic              out_free;
    logic [c8core_pkg::SP_W-1:0]  sp_dec;

    assign x      = r_op[11:8];
    assign y      = r_op[7:4];
    assign n      = r_op[3:0];
    assign nn     = r_op[7:0];
    assign nnn    = r_op[AW-1:0];
    assign vx     = r_v[x];
    assign vy     = r_v[y];
    assign pc2    = r_pc + AW'(2);
    assign pc4    = r_pc + AW'(4);
    assign ia     = r_i[AW-1:0] + AW'(r_cnt);
    assign sum9   = {1'b0, vx} + {1'b0, vy};
    assign sum17  = {1'b0, r_i} + 17'(vx);
    assign key_hit = (vx[7:4] == 4'd0) && r_item.key_state[vx[3:0]];
    assign key_any = (r_item.key_state != 16'd0);
    assign sp_dec  = r_sp - c8core_pkg::SP_W'(1);
    assign spr_wide = {i_ram_rdata, 56'd0, i_ram_rdata, 56'd0} >> r_sx[c8core_pkg::COL_W-1:0];
    assign spr_mask = spr_wide[SW-1:0];
    assign spr_row  = r_sy[c8core_pkg::ROW_W-1:0] + c8core_pkg::ROW_W'(r_cnt);
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        key_top = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (r_item.key_state[k]) key_top = 4'(k);
        end
    end

    assign o_ctl.pop      = (r_state == S_IDLE) && i_cmd_valid;
    assign o_ctl.clearing = (r_state == S_CLEAR);
    assign o_valid        = r_ovalid;
    assign o_data         = r_odata;

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_addr  = ia;
        o_ram_wdata = 8'd0;
        case (r_state)
            S_CLEAR: begin
                o_ram_we   = 1'b1;
                o_ram_addr = r_clr;
            end
            S_IDLE: begin
                o_ram_we    = i_cmd_valid && (i_cmd.kind == c8core_pkg::K_MEM_WR);
                o_ram_addr  = (i_cmd.kind == c8core_pkg::K_EXEC) ? r_pc : i_cmd.item.mem_address;
                o_ram_wdata = i_cmd.item.mem_data;
            end
            S_FETCH_LO: o_ram_addr = r_pc + AW'(1);
            S_BCD: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = c8core_pkg::bcd_digit(vx, r_cnt[1:0]);
            end
            S_STORE: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = r_v[r_cnt];
            end
            default: o_ram_addr = ia;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_sp     <= '0;
            r_pc     <= c8core_pkg::PC_RESET;
            r_i      <= 16'd0;
            r_delay  <= 8'd0;
            r_sound  <= 8'd0;
            r_draw   <= 1'b1;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
            for (int k = 0; k < c8core_pkg::STACK_DEPTH; k++) r_stack[k] <= '0;
            for (int k = 0; k < c8core_pkg::SCREEN_HEIGHT; k++) r_frame[k] <= '0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(c8core_pkg::MEM_BYTES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_item <= i_cmd.item;
                        r_rb   <= 8'd0;
                        r_rp   <= '0;
                        r_wait <= 1'b0;
                        r_serr <= 1'b0;
                        case (i_cmd.kind)
                            c8core_pkg::K_EXEC:   r_state <= S_FETCH_LO;
                            c8core_pkg::K_MEM_WR: r_state <= S_DONE;
                            c8core_pkg::K_MEM_RD: r_state <= S_MEM_RD;
                            default: begin
                                r_rp    <= r_frame[i_cmd.item.row_index];
                                r_draw  <= 1'b0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MEM_RD: begin
                    r_rb    <= i_ram_rdata;
                    r_state <= S_DONE;
                end
                S_FETCH_LO: begin
                    r_op[15:8] <= i_ram_rdata;
                    r_state    <= S_DECODE;
                end
                S_DECODE: begin
                    r_op[7:0] <= i_ram_rdata;
                    r_state   <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_TICK;
                    r_cnt   <= 4'd0;
                    if (r_op != 16'd0) begin
                        r_pc <= pc2;
                        case (r_op[15:12])
                            4'h0: begin
                                if (r_op == 16'h00E0) begin
                                    for (int k = 0; k < c8core_pkg::SCREEN_HEIGHT; k++) begin
                                        r_frame[k] <= '0;
                                    end
                                    r_draw <= 1'b1;
                                end else if (r_op == 16'h00EE) begin
                                    if (r_sp != '0) begin
                                        r_sp <= sp_dec;
                                        r_pc <= r_stack[sp_dec[c8core_pkg::STK_IW-1:0]] + AW'(2);
                                    end else begin
                                        r_pc <= AW'(2);
                                    end
                                end else begin
                                    r_pc <= nnn;
                                end
                            end
                            4'h1: r_pc <= nnn;
                            4'h2: begin
                                if (r_sp < c8core_pkg::SP_W'(c8core_pkg::STACK_DEPTH)) begin
                                    r_stack[r_sp[c8core_pkg::STK_IW-1:0]] <= r_pc;
                                    r_sp <= r_sp + c8core_pkg::SP_W'(1);
                                    r_pc <= nnn;
                                end else begin
                                    r_serr <= 1'b1;
                                end
                            end
                            4'h3: if (vx == nn) r_pc <= pc4;
                            4'h4: if (vx != nn) r_pc <= pc4;
                            4'h5: if (vx == vy) r_pc <= pc4;
                            4'h6: r_v[x] <= nn;
                            4'h7: r_v[x] <= vx + nn;
                            4'h8: begin
                                case (n)
                                    4'h0: r_v[x] <= vy;
                                    4'h1: r_v[x] <= vx | vy;
                                    4'h2: r_v[x] <= vx & vy;
                                    4'h3: r_v[x] <= vx ^ vy;
                                    4'h4: begin
                                        r_v[15] <= 8'(sum9[8]);
                                        r_v[x]  <= sum9[7:0];
                                    end
                                    4'h5: begin
                                        r_v[15] <= 8'(vx >= vy);
                                        r_v[x]  <= vx - vy;
                                    end
                                    4'h6: begin
                                        r_v[15] <= 8'(vx[0]);
                                        r_v[x]  <= vx >> 1;
                                    end
                                    4'h7: begin
                                        r_v[15] <= 8'(vy >= vx);
                                        r_v[x]  <= vy - vx;
                                    end
                                    4'hE: begin
                                        r_v[15] <= 8'(vx[7]);
                                        r_v[x]  <= vx << 1;
                                    end
                                    default: ;
                                endcase
                            end
                            4'h9: if (vx != vy) r_pc <= pc4;
                            4'hA: r_i <= 16'(nnn);
                            4'hB: r_pc <= nnn + AW'(r_v[0]);
                            4'hC: r_v[x] <= r_item.random_value & nn;
                            4'hD: begin
                                r_v[15] <= 8'd0;
                                r_sx    <= vx;
                                r_sy    <= vy;
                                r_draw  <= 1'b1;
                                if (n != 4'd0) r_state <= S_SPR_RD;
                            end
                            4'hE: begin
                                if (nn == 8'h9E && key_hit)  r_pc <= pc4;
                                if (nn == 8'hA1 && !key_hit) r_pc <= pc4;
                            end
                            default: begin
                                case (nn)
                                    8'h07: r_v[x] <= r_delay;
                                    8'h0A: begin
                                        if (key_any) begin
                                            r_v[x] <= 8'(key_top);
                                        end else begin
                                            r_wait <= 1'b1;
                                            r_pc   <= r_pc;
                                        end
                                    end
                                    8'h15: r_delay <= vx;
                                    8'h18: r_sound <= vx;
                                    8'h1E: begin
                                        r_v[15] <= 8'(sum17 > 17'h00FFF);
                                        if (x == 4'hF) r_i <= r_i + 16'(sum17 > 17'h00FFF);
                                        else           r_i <= sum17[15:0];
                                    end
                                    8'h29: r_i <= 16'(vx) * 16'd5;
                                    8'h33: r_state <= S_BCD;
                                    8'h55: r_state <= S_STORE;
                                    8'h65: r_state <= S_LOAD_RD;
                                    default: ;
                                endcase
                            end
                        endcase
                    end
                end
                S_SPR_RD: r_state <= S_SPR_WR;
                S_SPR_WR: begin
                    if ((r_frame[spr_row] & spr_mask) != '0) r_v[15] <= 8'd1;
                    r_frame[spr_row] <= r_frame[spr_row] ^ spr_mask;
                    r_cnt   <= r_cnt + 4'd1;
                    r_state <= (r_cnt + 4'd1 == n) ? S_TICK : S_SPR_RD;
                end
                S_BCD: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd2) r_state <= S_TICK;
                end
                S_STORE: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == x) begin
                        r_i     <= r_i + 16'(x) + 16'd1;
                        r_state <= S_TICK;
                    end
                end
                S_LOAD_RD: r_state <= S_LOAD_WR;
                S_LOAD_WR: begin
                    r_v[r_cnt] <= i_ram_rdata;
                    r_cnt      <= r_cnt + 4'd1;
                    if (r_cnt == x) begin
                        r_i     <= r_i + 16'(x) + 16'd1;
                        r_state <= S_TICK;
                    end else begin
                        r_state <= S_LOAD_RD;
                    end
                end
                S_TICK: begin
                    if (r_delay != 8'd0) r_delay <= r_delay - 8'd1;
                    if (r_sound != 8'd0) r_sound <= r_sound - 8'd1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid                <= 1'b1;
                        r_odata.read_byte       <= r_rb;
                        r_odata.row_pixels      <= r_rp;
                        r_odata.program_counter <= r_pc;
                        r_odata.screen_changed  <= r_draw;
                        r_odata.sound_active    <= (r_sound != 8'd0);
                        r_odata.waiting_for_key <= r_wait;
                        r_odata.stack_error     <= r_serr;
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: design/c8core_checker.sv
// Port-level checks on the CHIP-8 instruction core, bound to the top level.
// Depends on c8core_pkg.
`default_nettype none
module c8core_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_valid,
    input wire c8core_pkg::t_out o_data,
    input wire logic             i_stall
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word after reset");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.waiting_for_key |-> !o_data.stack_error)
        else $error("key wait and stack error together");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.read_byte != 8'd0) |-> (o_data.row_pixels == '0))
        else $error("memory byte and row pixels together");

    a_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.row_pixels != '0) |-> !o_data.screen_changed)
        else $error("draw flag left set by row read");
endmodule

bind chip8_instruction_core_unit c8core_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);
`default_nettype wire

FILE: test/tb.sv
// Testbench for chip8_instruction_core_unit: drives words on the input channel,
// predicts every result with a behavioural CHIP-8 model and checks the output words.
// Depends on c8core_pkg and the design files.
`timescale 1ns / 100ps
module tb;
    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    c8core_pkg::t_in  i_data = '0;
    logic             i_stall = 1'b0;
    logic             o_stall;
    logic             o_valid;
    c8core_pkg::t_out o_data;

    chip8_instruction_core_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_data(i_data),
        .o_stall(o_stall), .o_valid(o_valid), .o_data(o_data), .i_stall(i_stall)
    );

    always #6 i_clk = ~i_clk;

    logic [7:0]  cpu_mem [0:4095];
    logic [63:0] cpu_screen [0:31];
    logic [7:0]  cpu_v [0:15];
    logic [11:0] cpu_stack [0:15];
    int          cpu_sp;
    logic [11:0] cpu_pc;
    logic [15:0] cpu_i;
    logic [7:0]  cpu_delay, cpu_sound;
    logic        cpu_draw;

    c8core_pkg::t_out expected_words [$];
    int   mismatches = 0;
    logic stall_random = 1'b1;

    task automatic model_clear();
        for (int a = 0; a < 4096; a++) cpu_mem[a] = 8'h00;
        for (int r = 0; r < 32; r++) cpu_screen[r] = '0;
        for (int r = 0; r < 16; r++) begin
            cpu_v[r] = 8'h00;
            cpu_stack[r] = '0;
        end
        cpu_sp = 0;
        cpu_pc = 12'h200;
        cpu_i = '0;
        cpu_delay = '0;
        cpu_sound = '0;
        cpu_draw = 1'b1;
    endtask

    function automatic logic [7:0] mem_at(int a);
        return cpu_mem[a & 12'hFFF];
    endfunction

    function automatic void cpu_execute(input logic [15:0] keys, input logic [7:0] rnd,
                                        output logic wait_key, output logic serr);
        logic [15:0] op;
        int x, y, next, col, row;
        logic [7:0] nn, a, b, bits;
        logic [11:0] nnn;
        logic found;
        logic [7:0] k;
        wait_key = 1'b0;
        serr = 1'b0;
        op = {mem_at(cpu_pc), mem_at(cpu_pc + 1)};
        x = op[11:8];
        y = op[7:4];
        nn = op[7:0];
        nnn = op[11:0];
        next = cpu_pc + 2;
        if (op == 16'h0000) return;
        case (op[15:12])
            4'h0: begin
                if (op == 16'h00E0) begin
                    for (int r = 0; r < 32; r++) cpu_screen[r] = '0;
                    cpu_draw = 1'b1;
                end else if (op == 16'h00EE) begin
                    int ret;
                    ret = 0;
                    if (cpu_sp > 0) begin
                        cpu_sp--;
                        ret = cpu_stack[cpu_sp];
                    end
                    next = ret + 2;
                end else next = nnn;
            end
            4'h1: next = nnn;
            4'h2: begin
                if (cpu_sp < 16) begin
                    cpu_stack[cpu_sp] = cpu_pc;
                    cpu_sp++;
                    next = nnn;
                end else serr = 1'b1;
            end
            4'h3: if (cpu_v[x] == nn) next += 2;
            4'h4: if (cpu_v[x] != nn) next += 2;
            4'h5: if (cpu_v[x] == cpu_v[y]) next += 2;
            4'h6: cpu_v[x] = nn;
            4'h7: cpu_v[x] = cpu_v[x] + nn;
            4'h8: begin
                a = cpu_v[x];
                b = cpu_v[y];
                case (op[3:0])
                    4'h0: cpu_v[x] = b;
                    4'h1: cpu_v[x] = a | b;
                    4'h2: cpu_v[x] = a & b;
                    4'h3: cpu_v[x] = a ^ b;
                    4'h4: begin
                        cpu_v[15] = ({1'b0, a} + b > 9'hFF);
                        cpu_v[x] = a + b;
                    end
                    4'h5: begin
                        cpu_v[15] = (a >= b);
                        cpu_v[x] = a - b;
                    end
                    4'h6: begin
                        cpu_v[15] = a[0];
                        cpu_v[x] = a >> 1;
                    end
                    4'h7: begin
                        cpu_v[15] = (b >= a);
                        cpu_v[x] = b - a;
                    end
                    4'hE: begin
                        cpu_v[15] = a[7];
                        cpu_v[x] = a << 1;
                    end
                    default: ;
                endcase
            end
            4'h9: if (cpu_v[x] != cpu_v[y]) next += 2;
            4'hA: cpu_i = nnn;
            4'hB: next = nnn + cpu_v[0];
            4'hC: cpu_v[x] = rnd & nn;
            4'hD: begin
                a = cpu_v[x];
                b = cpu_v[y];
                cpu_v[15] = 8'h00;
                for (int r = 0; r < op[3:0]; r++) begin
                    bits = mem_at(cpu_i + r);
                    row = (b + r) & 31;
                    for (int c = 0; c < 8; c++) begin
                        if (bits[7 - c]) begin
                            col = (a + c) & 63;
                            if (cpu_screen[row][63 - col]) cpu_v[15] = 8'h01;
                            cpu_screen[row][63 - col] ^= 1'b1;
                        end
                    end
                end
                cpu_draw = 1'b1;
            end
            4'hE: begin
                if (nn == 8'h9E) begin
                    if (cpu_v[x] < 16 && keys[cpu_v[x][3:0]]) next += 2;
                end else if (nn == 8'hA1) begin
                    if (!(cpu_v[x] < 16 && keys[cpu_v[x][3:0]])) next += 2;
                end
            end
            default: begin
                case (nn)
                    8'h07: cpu_v[x] = cpu_delay;
                    8'h0A: begin
                        found = 1'b0;
                        k = 8'h00;
                        for (int n = 0; n < 16; n++)
                            if (keys[n]) begin
                                found = 1'b1;
                                k = 8'(n);
                            end
                        if (!found) begin
                            wait_key = 1'b1;
                            next = cpu_pc;
                        end else cpu_v[x] = k;
                    end
                    8'h15: cpu_delay = cpu_v[x];
                    8'h18: cpu_sound = cpu_v[x];
                    8'h1E: begin
                        cpu_v[15] = ({16'h0, cpu_i} + cpu_v[x] > 32'hFFF);
                        cpu_i = cpu_i + cpu_v[x];
                    end
                    8'h29: cpu_i = 16'(cpu_v[x] * 5);
                    8'h33: begin
                        cpu_mem[cpu_i & 12'hFFF] = 8'(cpu_v[x] / 100);
                        cpu_mem[(cpu_i + 1) & 12'hFFF] = 8'((cpu_v[x] / 10) % 10);
                        cpu_mem[(cpu_i + 2) & 12'hFFF] = 8'(cpu_v[x] % 10);
                    end
                    8'h55: begin
                        for (int n = 0; n <= x; n++) cpu_mem[(cpu_i + n) & 12'hFFF] = cpu_v[n];
                        cpu_i = 16'(cpu_i + x + 1);
                    end
                    8'h65: begin
                        for (int n = 0; n <= x; n++) cpu_v[n] = mem_at(cpu_i + n);
                        cpu_i = 16'(cpu_i + x + 1);
                    end
                    default: ;
                endcase
            end
        endcase
        cpu_pc = next[11:0];
    endfunction

    function automatic c8core_pkg::t_out cpu_step(input c8core_pkg::t_in w);
        c8core_pkg::t_out res;
        logic wk, se;
        res = '0;
        wk = 1'b0;
        se = 1'b0;
        case (w.action)
            c8core_pkg::ACT_EXEC: begin
                cpu_execute(w.key_state, w.random_value, wk, se);
                if (cpu_delay != 0) cpu_delay--;
                if (cpu_sound != 0) cpu_sound--;
            end
            c8core_pkg::ACT_MEM_WR: cpu_mem[w.mem_address] = w.mem_data;
            c8core_pkg::ACT_MEM_RD: res.read_byte = cpu_mem[w.mem_address];
            default: begin
                res.row_pixels = cpu_screen[w.row_index];
                cpu_draw = 1'b0;
            end
        endcase
        res.program_counter = cpu_pc;
        res.screen_changed = cpu_draw;
        res.sound_active = (cpu_sound != 0);
        res.waiting_for_key = wk;
        res.stack_error = se;
        return res;
    endfunction

    function automatic c8core_pkg::t_in random_word();
        c8core_pkg::t_in w;
        w.action = 2'($urandom);
        w.mem_address = 12'($urandom);
        w.mem_data = 8'($urandom);
        w.row_index = 5'($urandom);
        w.key_state = 16'($urandom);
        w.random_value = 8'($urandom_range(0, 254));
        return w;
    endfunction

    task automatic send_word(input c8core_pkg::t_in w);
        int gap;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data <= w;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_words.push_back(cpu_step(w));
        @(negedge i_clk);
    endtask

    task automatic poke(input int a, input logic [7:0] d);
        c8core_pkg::t_in w;
        w = '0;
        w.action = c8core_pkg::ACT_MEM_WR;
        w.mem_address = 12'(a);
        w.mem_data = d;
        send_word(w);
    endtask

    task automatic run_op(input logic [15:0] keys, input logic [7:0] rnd);
        c8core_pkg::t_in w;
        w = '0;
        w.action = c8core_pkg::ACT_EXEC;
        w.key_state = keys;
        w.random_value = rnd;
        w.mem_address = 12'($urandom);
        w.mem_data = 8'($urandom);
        w.row_index = 5'($urandom);
        send_word(w);
    endtask

    task automatic exec_opcode(input logic [15:0] op, input logic [15:0] keys);
        poke(cpu_pc, op[15:8]);
        poke(cpu_pc + 1, op[7:0]);
        run_op(keys, 8'($urandom_range(0, 254)));
    endtask

    task automatic read_row(input int r);
        c8core_pkg::t_in w;
        w = random_word();
        w.action = c8core_pkg::ACT_ROW_RD;
        w.row_index = 5'(r);
        send_word(w);
    endtask

    task automatic test_directed();
        c8core_pkg::t_in w;
        w = '0;
        w.action = c8core_pkg::ACT_MEM_RD;
        w.mem_address = 12'hFFF;
        send_word(w);
        poke(12'hFFF, 8'hFF);
        w.mem_address = 12'hFFF;
        send_word(w);
        read_row(31);
        run_op(16'h0000, 8'h00);
        exec_opcode(16'h60FF, 16'h0);
        exec_opcode(16'h61FF, 16'h0);
        exec_opcode(16'h8014, 16'h0);
        exec_opcode(16'hF018, 16'h0);
        exec_opcode(16'hF00A, 16'h0000);
        exec_opcode(16'hF10A, 16'hFFFF);
        exec_opcode(16'h00EE, 16'h0);
        exec_opcode(16'hAFFE, 16'h0);
        exec_opcode(16'hD01F, 16'h0);
        read_row(0);
        exec_opcode(16'hD010, 16'h0);
        exec_opcode(16'hFF1E, 16'h0);
        exec_opcode(16'hC0FF, 16'h0);
        exec_opcode(16'hE09E, 16'hFFFF);
        for (int n = 0; n < 17; n++) exec_opcode(16'h2000 | cpu_pc, 16'h0);
        exec_opcode(16'h00E0, 16'h0);
        exec_opcode(16'h1FFE, 16'h0);
    endtask

    function automatic logic [15:0] random_opcode();
        logic [15:0] op;
        logic [7:0] fx [0:9];
        fx = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'hFF};
        op = 16'($urandom);
        case (op[15:12])
            4'h0: case ($urandom_range(0, 3))
                0: op = 16'h00E0;
                1: op = 16'h00EE;
                2: op = 16'h0000;
                default: ;
            endcase
            4'hE: op[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1;
            4'hF: op[7:0] = ($urandom_range(0, 7) == 0) ? op[7:0] : fx[$urandom_range(0, 9)];
            4'h8: if ($urandom_range(0, 7) != 0) op[3:0] = $urandom_range(0, 8) == 8
                      ? 4'hE : 4'($urandom_range(0, 7));
            default: ;
        endcase
        if (op[15:12] == 4'hD && $urandom_range(0, 3) != 0) op[3:0] = 4'($urandom_range(0, 4));
        return op;
    endfunction

    task automatic test_random_program();
        c8core_pkg::t_in w;
        for (int n = 0; n < 480; n++) begin
            case ($urandom_range(0, 9))
                0: begin
                    w = random_word();
                    w.action = c8core_pkg::ACT_MEM_RD;
                    send_word(w);
                end
                1: read_row($urandom_range(0, 31));
                2: begin
                    w = random_word();
                    w.action = c8core_pkg::ACT_MEM_WR;
                    send_word(w);
                end
                default: exec_opcode(random_opcode(),
                    $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom));
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_data);
            end else begin
                c8core_pkg::t_out e;
                e = expected_words.pop_front();
                if (o_data !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: expected %h actual %h", e, o_data);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        int hold;
        if (stall_random && o_valid && !i_stall) begin
            hold = $urandom_range(0, 17);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        model_clear();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_program();
        i_valid <= 1'b0;
        stall_random = 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #(12 * 1000000);
        $display("Mismatches found");
        $finish;
    end
endmodule
